@@ rtl/mcfir_pkg.sv @@
// Shared types, constants and control structs for the multichannel FIR block.
// No dependencies; every other file imports this package.
`default_nettype none

package mcfir_pkg;

	// sizing
	localparam int NUM_TAPS     = 64;
	localparam int NUM_CHANNELS = 4;
	localparam int SAMPLE_BITS  = 16;

	localparam int COEF_BITS = 16;
	localparam int CHAN_BITS = 2;                        // channel field width
	localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TAP_IDX_W = $clog2(NUM_TAPS);         // tap / ring pointer
	localparam int CNT_W     = $clog2(NUM_TAPS + 1);     // counts 0..NUM_TAPS
	localparam int HIST_LEN  = NUM_TAPS - 1;
	localparam int HIST_AW   = CH_IDX_W + TAP_IDX_W;
	localparam int HIST_DEPTH = NUM_CHANNELS * NUM_TAPS;
	localparam int CIDX_BITS = 6;                        // coef_index field width
	localparam int TAPCNT_BITS = 7;

	localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W    = PROD_W + CNT_W + 1;
	localparam int FRAC_BITS = 15;
	localparam int Y_W      = ACC_W - FRAC_BITS;
	localparam int OUT_BITS = 24;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (OUT_BITS - 1)) - 1);
	localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(64'sd1 <<< (OUT_BITS - 1));

	// item codes
	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// APB register map
	localparam int APB_AW = 2;
	localparam logic [APB_AW-1:0] ADDR_TAP_COUNT = APB_AW'(0);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [OUT_BITS-1:0]    out_val_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic                 load;     // latch a sample item, push history
		logic                 coef_wr;  // write one tap weight
		logic                 issue;    // start one MAC term
		logic [TAP_IDX_W-1:0] tap_idx;  // term index k
		logic                 emit;     // round, saturate, load output register
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] terms;        // MAC terms for the current sample
		logic             busy;         // MAC pipeline holds terms in flight
		logic             out_free;     // output register can take a result
	} dp_status_t;

endpackage

`default_nettype wire

@@ rtl/mcfir_if.sv @@
// Valid/ready channel interfaces for input items and filtered results.
// Depends on mcfir_pkg.
`default_nettype none

interface mcfir_in_if import mcfir_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [CHAN_BITS-1:0] channel;
	logic                 block_start;
	sample_t              sample_value;
	logic [CIDX_BITS-1:0] coef_index;
	coef_t                coef_value;

	modport source (output valid, opcode, channel, block_start, sample_value,
		coef_index, coef_value, input ready);
	modport sink (input valid, opcode, channel, block_start, sample_value,
		coef_index, coef_value, output ready);
endinterface

interface mcfir_out_if import mcfir_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHAN_BITS-1:0] out_channel;
	out_val_t             filtered_value;
	logic                 saturated;

	modport source (output valid, out_channel, filtered_value, saturated, input ready);
	modport sink (input valid, out_channel, filtered_value, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/mcfir_ctrl.sv @@
// Sequencer: accepts items, steps the MAC over the taps, hands off the result.
// Depends on mcfir_pkg.
`default_nettype none

module mcfir_ctrl import mcfir_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_opcode,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.tap_idx = k_q[TAP_IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == OP_SAMPLE) begin
						cmd.load = 1'b1;
						k_d      = '0;
						state_d  = ST_RUN;
					end else begin
						cmd.coef_wr = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (k_q < status.terms) begin
					cmd.issue = 1'b1;
					k_d       = k_q + CNT_W'(1);
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/mcfir_dp.sv @@
// Datapath: tap and history memories, per-channel ring pointers, one
// pipelined multiply-accumulate, rounding and the output register.
// Depends on mcfir_pkg.
`default_nettype none

module mcfir_dp import mcfir_pkg::*; (
	input  wire                       clk,
	input  wire                       arst_n,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	input  wire [TAPCNT_BITS-1:0]     tap_count,
	input  wire [CHAN_BITS-1:0]       channel,
	input  wire                       block_start,
	input  wire signed [SAMPLE_BITS-1:0] sample_value,
	input  wire [CIDX_BITS-1:0]       coef_index,
	input  wire signed [COEF_BITS-1:0] coef_value,
	input  wire                       out_ready,
	output logic                      out_valid,
	output logic [CHAN_BITS-1:0]      out_channel,
	output out_val_t                  filtered_value,
	output logic                      saturated
);

	// memories
	coef_t   coef_mem [NUM_TAPS];
	sample_t hist_mem [HIST_DEPTH];
	logic [NUM_TAPS-1:0] coef_vld_q;

	// per-channel ring state
	logic [TAP_IDX_W-1:0] wp_q   [NUM_CHANNELS];
	logic [TAP_IDX_W-1:0] fill_q [NUM_CHANNELS];

	// current item
	logic [CHAN_BITS-1:0] chan_q;
	logic [CH_IDX_W-1:0]  chw_q;
	logic [TAP_IDX_W-1:0] base_q;
	sample_t              x_q;
	logic [CNT_W-1:0]     terms_q;

	// MAC pipeline
	logic    vld_s1, first_s1, cvld_s1;
	coef_t   coef_s1;
	sample_t hist_s1;
	logic    vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// output register
	logic                 out_vld_q;
	logic [CHAN_BITS-1:0] out_ch_q;
	out_val_t             out_val_q;
	logic                 out_sat_q;

	logic [CH_IDX_W-1:0]  in_chw;
	logic [TAP_IDX_W-1:0] fill_eff;
	logic [CNT_W-1:0]     taps_eff, avail;
	logic [TAP_IDX_W-1:0] fill_next;
	logic [HIST_AW-1:0]   rd_addr;
	sample_t              op_x;
	coef_t                op_c;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  rsum;
	logic signed [Y_W-1:0]    y;

	always_comb begin
		in_chw    = CH_IDX_W'(channel % NUM_CHANNELS);
		fill_eff  = block_start ? '0 : fill_q[in_chw];
		taps_eff  = (tap_count > TAPCNT_BITS'(NUM_TAPS)) ? CNT_W'(NUM_TAPS)
			: CNT_W'(tap_count);
		avail     = CNT_W'(fill_eff) + CNT_W'(1);
		fill_next = (fill_eff == TAP_IDX_W'(HIST_LEN)) ? fill_eff
			: fill_eff + TAP_IDX_W'(1);
		rd_addr   = {chw_q, base_q - cmd.tap_idx};
		op_x      = first_s1 ? x_q : hist_s1;
		op_c      = cvld_s1 ? coef_s1 : '0;
		prod      = op_x * op_c;
		rsum      = acc_q + ROUND_HALF;
		y         = rsum[ACC_W-1:FRAC_BITS];
	end

	// memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.coef_wr)
			coef_mem[coef_index[TAP_IDX_W-1:0]] <= coef_value;
		if (cmd.load)
			hist_mem[{in_chw, wp_q[in_chw]}] <= sample_value;
		coef_s1 <= coef_mem[cmd.tap_idx];
		hist_s1 <= hist_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				wp_q[c]   <= '0;
				fill_q[c] <= '0;
			end
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.coef_wr && (int'(coef_index) < NUM_TAPS))
				coef_vld_q[coef_index[TAP_IDX_W-1:0]] <= 1'b1;
			if (cmd.load) begin
				wp_q[in_chw]   <= wp_q[in_chw] + TAP_IDX_W'(1);
				fill_q[in_chw] <= fill_next;
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.emit)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chan_q  <= channel;
			chw_q   <= in_chw;
			base_q  <= wp_q[in_chw];
			x_q     <= sample_value;
			terms_q <= (taps_eff < avail) ? taps_eff : avail;
		end
		first_s1 <= (cmd.tap_idx == '0);
		cvld_s1  <= coef_vld_q[cmd.tap_idx];
		prod_s2  <= prod;
		if (cmd.load)
			acc_q <= '0;
		else if (vld_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
		if (cmd.emit) begin
			out_ch_q <= chan_q;
			if (y > Y_MAX) begin
				out_val_q <= out_val_t'(Y_MAX);
				out_sat_q <= 1'b1;
			end else if (y < Y_MIN) begin
				out_val_q <= out_val_t'(Y_MIN);
				out_sat_q <= 1'b1;
			end else begin
				out_val_q <= out_val_t'(y);
				out_sat_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.terms    = terms_q;
		status.busy     = vld_s1 | vld_s2;
		status.out_free = !out_vld_q || out_ready;
		out_valid       = out_vld_q;
		out_channel     = out_ch_q;
		filtered_value  = out_val_q;
		saturated       = out_sat_q;
	end

endmodule

`default_nettype wire

@@ rtl/multichannel_fir_filter_unit.sv @@
// Top level of the multichannel FIR: APB register, sequencer and datapath.
// Depends on mcfir_pkg, mcfir_if, mcfir_ctrl, mcfir_dp.
//
// Usage notes
//  - req: input beats. opcode OP_COEF writes one Q1.15 tap weight and
//    produces no result; opcode OP_SAMPLE filters one sample of one of
//    four interleaved channels and produces exactly one rsp beat.
//    block_start zeroes that channel's history before the sample.
//  - rsp: channel echo, rounded 24-bit result, clip flag.
//  - APB: tap_count at byte address 0 (7 bits, reset 1, values above 64
//    act as 64, zero gives a zero result). Write only while idle.
//  - Rate: a coefficient beat leaves req.ready high. A sample beat drops
//    req.ready until its result is in the output register; no new beat is
//    taken meanwhile. The single shared MAC visits one tap a cycle (memory
//    read, multiply, accumulate stages) over T = min(tap_count, valid
//    history + 1) terms.
//  - The output register lets the next beat be accepted while a result
//    waits; if rsp stalls, the following sample finishes its MAC work and
//    then holds until the register frees.
//  - Reset: taps read as zero, all histories empty, tap_count = 1.
//    No clearing pass; valid bits and fill counts stand in for it.
`default_nettype none

module multichannel_fir_filter_unit import mcfir_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	// APB
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [APB_AW-1:0]  paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// streams
	mcfir_in_if.sink          req,
	mcfir_out_if.source       rsp
);

	logic [TAPCNT_BITS-1:0] tap_count_q;
	dp_cmd_t                cmd;
	dp_status_t             status;

	// register write on the access phase; pready is tied high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tap_count_q <= TAPCNT_BITS'(1);
		else if (psel && penable && pwrite && (paddr == ADDR_TAP_COUNT))
			tap_count_q <= pwdata[TAPCNT_BITS-1:0];
	end

	always_comb begin
		pready = 1'b1;
		prdata = (paddr == ADDR_TAP_COUNT) ? 32'(tap_count_q) : '0;
	end

	// sequencer
	mcfir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// memories and MAC
	mcfir_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.tap_count      (tap_count_q),
		.channel        (req.channel),
		.block_start    (req.block_start),
		.sample_value   (req.sample_value),
		.coef_index     (req.coef_index),
		.coef_value     (req.coef_value),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.out_channel    (rsp.out_channel),
		.filtered_value (rsp.filtered_value),
		.saturated      (rsp.saturated)
	);

endmodule

`default_nettype wire

@@ rtl/mcfir_checker.sv @@
// Port-level checks for the multichannel FIR top level, attached by bind.
// Depends on mcfir_pkg and multichannel_fir_filter_unit.
`default_nettype none

module mcfir_checker import mcfir_pkg::*; (
	input wire           clk,
	input wire           arst_n,
	input wire           req_valid,
	input wire           req_ready,
	input wire           req_opcode,
	input wire           rsp_valid,
	input wire           rsp_ready,
	input wire           rsp_saturated,
	input wire [OUT_BITS-1:0] rsp_value
);

	// a result is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp beat dropped while stalled");

	// a sample beat occupies the MAC, so no beat is taken the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_opcode == OP_SAMPLE) |=> !req_ready)
		else $error("req accepted during MAC work");

	// a coefficient beat leaves the block idle
	a_coef_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_opcode == OP_COEF) |=> req_ready)
		else $error("coefficient write stalled the input");

	// clip flag only at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_saturated |->
			(rsp_value == OUT_BITS'(Y_MAX)) || (rsp_value == OUT_BITS'(Y_MIN)))
		else $error("clip flag with unclipped value");

endmodule

bind multichannel_fir_filter_unit mcfir_checker u_mcfir_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_opcode    (req.opcode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_saturated (rsp.saturated),
	.rsp_value     (rsp.filtered_value)
);

`default_nettype wire

@@ tb/sv/mcfir_result_check.sv @@
`timescale 1ns / 100ps
// Result checker for the multichannel FIR: watches the APB bus and both streams,
// predicts every filtered beat and compares it field by field.
// Depends on mcfir_pkg and the mcfir_in_if / mcfir_out_if interfaces.

module mcfir_result_check import mcfir_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	mcfir_in_if               req,
	mcfir_out_if              rsp,
	output int                mismatch_count,
	output int                filt_pending
);

	localparam longint OUT_HI = (longint'(1) <<< (OUT_BITS - 1)) - 1;
	localparam longint OUT_LO = -(longint'(1) <<< (OUT_BITS - 1));
	localparam longint RND    = longint'(1) <<< (FRAC_BITS - 1);

	typedef struct packed {
		logic [CHAN_BITS-1:0] chan;
		out_val_t             value;
		logic                 clip;
	} filt_result_t;

	// local copy of the block state
	logic [TAPCNT_BITS-1:0] tap_count_q;
	coef_t                  coef_mem [NUM_TAPS];
	sample_t                hist_mem [NUM_CHANNELS][HIST_LEN];
	int unsigned            hist_fill [NUM_CHANNELS];

	filt_result_t expected_outputs[$];

	// One sample through the filter; updates that channel's history.
	function automatic filt_result_t filter_sample(logic [CHAN_BITS-1:0] chan, logic bstart,
			sample_t x);
		int unsigned  ch;
		int unsigned  taps;
		int           i;
		longint       acc;
		longint       y;
		filt_result_t r;
		ch = chan % NUM_CHANNELS;
		if (bstart) begin
			for (i = 0; i < HIST_LEN; i++)
				hist_mem[ch][i] = '0;
			hist_fill[ch] = 0;
		end
		taps = (tap_count_q > NUM_TAPS) ? NUM_TAPS : tap_count_q;
		acc = 0;
		for (i = 0; i < taps; i++) begin
			if (i == 0)
				acc += longint'(coef_mem[0]) * longint'(x);
			else if (i <= hist_fill[ch])
				acc += longint'(coef_mem[i]) * longint'(hist_mem[ch][i-1]);
		end
		for (i = HIST_LEN - 1; i > 0; i--)
			hist_mem[ch][i] = hist_mem[ch][i-1];
		hist_mem[ch][0] = x;
		if (hist_fill[ch] < HIST_LEN)
			hist_fill[ch]++;
		y = (acc + RND) >>> FRAC_BITS;
		r.clip = 1'b0;
		if (y > OUT_HI) begin
			y = OUT_HI;
			r.clip = 1'b1;
		end
		if (y < OUT_LO) begin
			y = OUT_LO;
			r.clip = 1'b1;
		end
		r.chan  = chan;
		r.value = out_val_t'(y);
		return r;
	endfunction

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int           c;
		int           i;
		filt_result_t want;
		if (!arst_n) begin
			tap_count_q = TAPCNT_BITS'(1);
			for (i = 0; i < NUM_TAPS; i++)
				coef_mem[i] = '0;
			for (c = 0; c < NUM_CHANNELS; c++) begin
				hist_fill[c] = 0;
				for (i = 0; i < HIST_LEN; i++)
					hist_mem[c][i] = '0;
			end
			expected_outputs.delete();
			mismatch_count = 0;
			filt_pending   = 0;
		end else begin
			// drain side first: a result never belongs to a beat taken at the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_outputs.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result beat, expected none, actual ch %0d value %0d",
						$time, rsp.out_channel, rsp.filtered_value);
				end else begin
					want = expected_outputs.pop_front();
					check_field("out_channel", want.chan, rsp.out_channel);
					check_field("filtered_value", want.value, rsp.filtered_value);
					check_field("saturated", want.clip, rsp.saturated);
				end
			end
			if (req.valid && req.ready) begin
				if (req.opcode == OP_COEF) begin
					if (req.coef_index < NUM_TAPS)
						coef_mem[req.coef_index] = req.coef_value;
				end else begin
					expected_outputs.push_back(filter_sample(req.channel, req.block_start,
						req.sample_value));
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_TAP_COUNT)
				tap_count_q = pwdata[TAPCNT_BITS-1:0];
			filt_pending = expected_outputs.size();
		end
	end

endmodule

@@ tb/sv/tb_multichannel_fir_filter_unit.sv @@
`timescale 1ns / 100ps
// Top of the multichannel FIR testbench: clock, reset, APB writes, stream stimulus
// and the verdict. Depends on mcfir_pkg, the stream interfaces and mcfir_result_check.

module tb_multichannel_fir_filter_unit;
	import mcfir_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000; // quiet cycles before giving up
	localparam int DRAIN_CYCLES    = 80;   // outlasts a sample's MAC work with T up to 64 taps
	localparam int END_CYCLES      = 100;
	localparam int RSP_HOLD_CYCLES = 400;  // long output stall, fills the block
	localparam int SEG_ITEMS       = 100;  // random beats per tap setting
	localparam int NUM_SEGS        = 6;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          rsp_hold_req;
	int          mismatch_count;
	int          filt_pending;

	mcfir_in_if  req();
	mcfir_out_if rsp();

	multichannel_fir_filter_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.rsp     (rsp)
	);

	// prediction and comparison live beside the block
	mcfir_result_check u_filter_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.req            (req),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.filt_pending   (filt_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random 16-bit word, leaning on the extremes now and then.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// One beat on req. Called right after a falling edge, returns right after one.
	// valid is left high; the next call either idles it or overwrites the payload,
	// so valid never sees two assignments in one step.
	task automatic send_item(input logic op, input logic [CHAN_BITS-1:0] ch, input logic bs,
			input sample_t sv, input logic [CIDX_BITS-1:0] ci, input coef_t cv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.channel      <= ch;
		req.block_start  <= bs;
		req.sample_value <= sv;
		req.coef_index   <= ci;
		req.coef_value   <= cv;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Coefficient beat; the sample fields carry noise since the block ignores them.
	task automatic coef_beat(input logic [CIDX_BITS-1:0] idx, input coef_t val);
		send_item(OP_COEF, CHAN_BITS'($urandom), 1'($urandom), pick_word(), idx, val);
	endtask

	// Sample beat; the coefficient fields carry noise.
	task automatic sample_beat(input logic [CHAN_BITS-1:0] ch, input logic bs, input sample_t x);
		send_item(OP_SAMPLE, ch, bs, x, CIDX_BITS'($urandom), pick_word());
	endtask

	// Random beat for a given tap setting. Coefficient writes favor the taps in use,
	// samples favor channel 0 and rarely restart a block, so long histories build up.
	task automatic send_random(input int unsigned tc);
		int unsigned             roll;
		int unsigned             used;
		logic [CIDX_BITS-1:0]    idx;
		logic [CHAN_BITS-1:0]    ch;
		used = (tc > NUM_TAPS) ? NUM_TAPS : tc;
		roll = $urandom_range(0, 99);
		if (used > 0 && $urandom_range(0, 1) == 0)
			idx = CIDX_BITS'($urandom_range(0, used - 1));
		else
			idx = CIDX_BITS'($urandom);
		ch = ($urandom_range(0, 1) == 0) ? CHAN_BITS'(0) : CHAN_BITS'($urandom);
		if (roll < 30)
			send_item(OP_COEF, ch, 1'($urandom), pick_word(), idx, pick_word());
		else
			send_item(OP_SAMPLE, ch, ($urandom_range(0, 63) == 0), pick_word(), idx, pick_word());
	endtask

	// Register write while the block is quiet: stop offering, let every expected
	// result land, give the MAC time to settle, then a setup and an access phase.
	task automatic set_tap_count(input logic [TAPCNT_BITS-1:0] val);
		req.valid <= 1'b0;
		while (filt_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TAP_COUNT;
		pwdata  <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Output side: random stalls, plus one long hold-off on request so that
	// the output register and the MAC both fill and req.ready drops.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(negedge clk);
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: counts cycles with no beat on any port.
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned seg;
		int unsigned n;
		int unsigned tc;

		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req.valid        = 1'b0;
		req.opcode       = OP_COEF;
		req.channel      = '0;
		req.block_start  = 1'b0;
		req.sample_value = '0;
		req.coef_index   = '0;
		req.coef_value   = '0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		rsp_hold_req     = 1'b0;
		arst_n           = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed: reset state, one tap ---
		sample_beat(2'd0, 1'b0, 16'sd1234);      // taps still zero after reset
		coef_beat(6'd0, 16'sh7fff);
		sample_beat(2'd1, 1'b1, -16'sd32768);    // most negative sample, max tap
		coef_beat(6'd0, 16'sh8000);
		sample_beat(2'd2, 1'b0, -16'sd32768);    // both operands at the negative rail
		sample_beat(2'd3, 1'b0, 16'sd32767);
		coef_beat(6'd0, 16'sd1);
		sample_beat(2'd0, 1'b0, -16'sd16384);    // negative half: rounds up to zero
		sample_beat(2'd0, 1'b0, -16'sd16385);    // just past half: floor to -1
		sample_beat(2'd0, 1'b0, 16'sd16384);     // positive half rounds up

		// --- full length, taps at index 1 and at the far end of the store ---
		set_tap_count(7'd64);
		coef_beat(6'd63, 16'sh8000);
		coef_beat(6'd1, 16'sh7fff);
		sample_beat(2'd3, 1'b1, -16'sd32768);    // fresh block, history empty
		sample_beat(2'd3, 1'b0, 16'sd32767);     // one past sample now in use
		sample_beat(2'd1, 1'b0, 16'sd32767);

		// --- no taps: result is zero whatever the input ---
		set_tap_count(7'd0);
		sample_beat(2'd0, 1'b0, 16'sd32767);
		sample_beat(2'd1, 1'b1, -16'sd32768);

		// --- tap count beyond the store acts as the full length ---
		set_tap_count(7'd127);
		sample_beat(2'd2, 1'b0, -16'sd32768);
		sample_beat(2'd3, 1'b0, 16'sd5);

		// --- random segments; tap settings short, zero or full length ---
		for (seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: tc = 64;
				1: tc = $urandom_range(2, 12);
				2: tc = 127;
				3: tc = $urandom_range(1, 8);
				4: tc = 0;
				default: tc = $urandom_range(3, 20);
			endcase
			set_tap_count(TAPCNT_BITS'(tc));
			for (n = 0; n < SEG_ITEMS; n++) begin
				// sender keeps offering while the output side sits on its hands
				if (seg == NUM_SEGS - 1 && n == 20)
					rsp_hold_req = 1'b1;
				send_random(tc);
			end
		end

		req.valid <= 1'b0;
		while (filt_pending != 0)
			@(negedge clk);
		repeat (END_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && filt_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mcfir_pkg.sv
rtl/mcfir_if.sv
rtl/mcfir_ctrl.sv
rtl/mcfir_dp.sv
rtl/multichannel_fir_filter_unit.sv
rtl/mcfir_checker.sv
tb/sv/mcfir_result_check.sv
tb/sv/tb_multichannel_fir_filter_unit.sv
